/* src/psd_pkg.sv */
// psd_pkg: widths, part codes and beat types for the point to segment distance pipeline
// no dependencies; imported by point_segment_distance
`default_nettype none
package psd_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int FRACTION_BITS = 8;

  localparam int DIST_WIDTH = COORD_WIDTH + FRACTION_BITS + 1;
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
  localparam int DOT_WIDTH  = PROD_WIDTH + 1;
  localparam int MAG_WIDTH  = PROD_WIDTH;
  localparam int HALF_WIDTH = MAG_WIDTH / 2;
  localparam int NUM_WIDTH  = 2 * MAG_WIDTH;
  localparam int NFULL_WIDTH = NUM_WIDTH + 2 * FRACTION_BITS;
  localparam int QUO_WIDTH  = 2 * DIST_WIDTH;
  localparam int ROOT_STAGES = DIST_WIDTH;

  localparam logic [1:0] PART_START = 2'd0;
  localparam logic [1:0] PART_END   = 2'd1;
  localparam logic [1:0] PART_MID   = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance_q8;
    logic [1:0]            nearest_part;
  } psd_out_t;

endpackage
`default_nettype wire

/* src/point_segment_distance.sv */
// throughput: one beat per cycle unless a held result stalls the pipe
// one divider stage per quotient bit, one root stage per result bit
// a held result stalls the whole pipe, bubbles are not squeezed out
// reset clears only the valid bits; data registers are not reset
// top level: point to segment distance, floor(256*dist), fully pipelined
// depends on psd_pkg
`default_nettype none
module point_segment_distance
  import psd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire psd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output psd_out_t      out_data
);

  logic en;

  // stage 1: differences
  logic                         v1_r;
  logic signed [DIFF_WIDTH-1:0] a_r, b_r, c_r, d_r, f_r, g_r;
  // stage 2: products
  logic                         v2_r;
  logic signed [PROD_WIDTH-1:0] ac_r, bd_r, cc_r, dd_r, aa_r, bb_r, ff_r, gg_r, ad_r, bc_r;
  // stage 3: sums
  logic                         v3_r;
  logic signed [DOT_WIDTH-1:0]  dot_r;
  logic [MAG_WIDTH-1:0]         len_r, sqa_r, sqf_r, crm_r;
  // stage 4: pick the nearest part, split square of cross
  logic                         v4_r;
  logic [1:0]                   part4_r;
  logic [MAG_WIDTH-1:0]         sqsel_r, len4_r;
  logic [MAG_WIDTH-1:0]         phh_r, phl_r, pll_r;

  // divider chain, index 0 loaded by stage 5
  logic                  dv_r   [QUO_WIDTH+1];
  logic [MAG_WIDTH-1:0]  drem_r [QUO_WIDTH+1];
  logic [QUO_WIDTH-1:0]  dq_r   [QUO_WIDTH+1];
  logic [MAG_WIDTH-1:0]  dden_r [QUO_WIDTH+1];
  logic [1:0]            dpart_r[QUO_WIDTH+1];
  logic [MAG_WIDTH-1:0]  drem_nxt[QUO_WIDTH];
  logic [QUO_WIDTH-1:0]  dq_nxt  [QUO_WIDTH];

  // root chain
  logic                  sv_r    [ROOT_STAGES];
  logic [DIST_WIDTH:0]   srem_r  [ROOT_STAGES];
  logic [DIST_WIDTH-1:0] sroot_r [ROOT_STAGES];
  logic [QUO_WIDTH-1:0]  sbits_r [ROOT_STAGES];
  logic [1:0]            spart_r [ROOT_STAGES];
  logic [DIST_WIDTH:0]   srem_nxt [ROOT_STAGES];
  logic [DIST_WIDTH-1:0] sroot_nxt[ROOT_STAGES];
  logic [QUO_WIDTH-1:0]  sbits_nxt[ROOT_STAGES];

  logic [NUM_WIDTH-1:0]   crsq;
  logic [NUM_WIDTH-1:0]   num;
  logic [NFULL_WIDTH-1:0] nfull;
  logic signed [DOT_WIDTH-1:0] cross_s;

  assign en        = !sv_r[ROOT_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = sv_r[ROOT_STAGES-1];
  assign out_data.distance_q8  = sroot_r[ROOT_STAGES-1];
  assign out_data.nearest_part = spart_r[ROOT_STAGES-1];

  assign cross_s = DOT_WIDTH'(ad_r) - DOT_WIDTH'(bc_r);

  // cross magnitude squared from three half width products
  assign crsq = (NUM_WIDTH'(phh_r) << MAG_WIDTH) + (NUM_WIDTH'(phl_r) << (HALF_WIDTH + 1))
              + NUM_WIDTH'(pll_r);
  assign num   = (part4_r == PART_MID) ? crsq : NUM_WIDTH'(sqsel_r);
  assign nfull = NFULL_WIDTH'(num) << (2 * FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DIFF_WIDTH'(in_data.point_x) - DIFF_WIDTH'(in_data.start_x);
      b_r <= DIFF_WIDTH'(in_data.point_y) - DIFF_WIDTH'(in_data.start_y);
      c_r <= DIFF_WIDTH'(in_data.end_x)   - DIFF_WIDTH'(in_data.start_x);
      d_r <= DIFF_WIDTH'(in_data.end_y)   - DIFF_WIDTH'(in_data.start_y);
      f_r <= DIFF_WIDTH'(in_data.point_x) - DIFF_WIDTH'(in_data.end_x);
      g_r <= DIFF_WIDTH'(in_data.point_y) - DIFF_WIDTH'(in_data.end_y);

      ac_r <= a_r * c_r;
      bd_r <= b_r * d_r;
      cc_r <= c_r * c_r;
      dd_r <= d_r * d_r;
      aa_r <= a_r * a_r;
      bb_r <= b_r * b_r;
      ff_r <= f_r * f_r;
      gg_r <= g_r * g_r;
      ad_r <= a_r * d_r;
      bc_r <= b_r * c_r;

      dot_r <= DOT_WIDTH'(ac_r) + DOT_WIDTH'(bd_r);
      len_r <= MAG_WIDTH'(cc_r) + MAG_WIDTH'(dd_r);
      sqa_r <= MAG_WIDTH'(aa_r) + MAG_WIDTH'(bb_r);
      sqf_r <= MAG_WIDTH'(ff_r) + MAG_WIDTH'(gg_r);
      crm_r <= cross_s[DOT_WIDTH-1] ? MAG_WIDTH'(-cross_s) : MAG_WIDTH'(cross_s);

      // zero length segment falls back to the first endpoint
      if (len_r == '0 || dot_r[DOT_WIDTH-1]) begin
        part4_r <= PART_START;
        sqsel_r <= sqa_r;
      end else if (dot_r > $signed({1'b0, len_r})) begin
        part4_r <= PART_END;
        sqsel_r <= sqf_r;
      end else begin
        part4_r <= PART_MID;
        sqsel_r <= sqa_r;
      end
      len4_r <= len_r;
      phh_r  <= crm_r[MAG_WIDTH-1:HALF_WIDTH] * crm_r[MAG_WIDTH-1:HALF_WIDTH];
      phl_r  <= crm_r[MAG_WIDTH-1:HALF_WIDTH] * crm_r[HALF_WIDTH-1:0];
      pll_r  <= crm_r[HALF_WIDTH-1:0] * crm_r[HALF_WIDTH-1:0];
    end
  end

  // divider: one restoring step per quotient bit, endpoint cases divide by one
  always_comb begin
    logic [MAG_WIDTH:0] t;
    logic               ge;
    for (int k = 0; k < QUO_WIDTH; k++) begin
      t  = {drem_r[k], dq_r[k][QUO_WIDTH-1]};
      ge = (t >= {1'b0, dden_r[k]});
      drem_nxt[k] = ge ? MAG_WIDTH'(t - {1'b0, dden_r[k]}) : t[MAG_WIDTH-1:0];
      dq_nxt[k]   = {dq_r[k][QUO_WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUO_WIDTH; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v4_r;
      for (int k = 1; k <= QUO_WIDTH; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0]  <= nfull[NFULL_WIDTH-1:QUO_WIDTH];
      dq_r[0]    <= nfull[QUO_WIDTH-1:0];
      dden_r[0]  <= (part4_r == PART_MID) ? len4_r : MAG_WIDTH'(1);
      dpart_r[0] <= part4_r;
      for (int k = 1; k <= QUO_WIDTH; k++) begin
        drem_r[k]  <= drem_nxt[k-1];
        dq_r[k]    <= dq_nxt[k-1];
        dden_r[k]  <= dden_r[k-1];
        dpart_r[k] <= dpart_r[k-1];
      end
    end
  end

  // integer square root, two radicand bits per stage
  always_comb begin
    logic [DIST_WIDTH:0]   rem_in;
    logic [DIST_WIDTH-1:0] root_in;
    logic [QUO_WIDTH-1:0]  bits_in;
    logic [DIST_WIDTH+2:0] t;
    logic [DIST_WIDTH+1:0] trial;
    logic                  ge;
    for (int j = 0; j < ROOT_STAGES; j++) begin
      if (j == 0) begin
        rem_in  = '0;
        root_in = '0;
        bits_in = dq_r[QUO_WIDTH];
      end else begin
        rem_in  = srem_r[(j == 0) ? 0 : j-1];
        root_in = sroot_r[(j == 0) ? 0 : j-1];
        bits_in = sbits_r[(j == 0) ? 0 : j-1];
      end
      t     = {rem_in, bits_in[QUO_WIDTH-1:QUO_WIDTH-2]};
      trial = {root_in, 2'b01};
      ge    = (t >= {1'b0, trial});
      srem_nxt[j]  = ge ? (DIST_WIDTH+1)'(t - {1'b0, trial}) : t[DIST_WIDTH:0];
      sroot_nxt[j] = {root_in[DIST_WIDTH-2:0], ge};
      sbits_nxt[j] = bits_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ROOT_STAGES; j++) sv_r[j] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= dv_r[QUO_WIDTH];
      for (int j = 1; j < ROOT_STAGES; j++) sv_r[j] <= sv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spart_r[0] <= dpart_r[QUO_WIDTH];
      for (int j = 0; j < ROOT_STAGES; j++) begin
        srem_r[j]  <= srem_nxt[j];
        sroot_r[j] <= sroot_nxt[j];
        sbits_r[j] <= sbits_nxt[j];
      end
      for (int j = 1; j < ROOT_STAGES; j++) spart_r[j] <= spart_r[j-1];
    end
  end

endmodule
`default_nettype wire
